// ----- sv/plist_pkg.sv -----
// Shared request codes, status codes and result type for the positional list engine.
`timescale 1ns / 1ps

package plist_pkg;

    localparam int REQ_W  = 3;
    localparam int POS_W  = 9;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 9;
    localparam int ST_W   = 2;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] data_out;
        logic [POS_W-1:0]         found_position;
        logic [LEN_W-1:0]         length;
    } res_t;

endpackage

// ----- sv/plist_mem.sv -----
// Element store: one write port and one registered read port.
`timescale 1ns / 1ps

module plist_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/plist_seq.sv -----
// Request sequencer: checks positions, walks the store to shift or search, keeps the count.
`timescale 1ns / 1ps

module plist_seq #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32,
    parameter int ADDR_W     = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [plist_pkg::REQ_W-1:0]         in_req_type,
    input  logic [plist_pkg::POS_W-1:0]         in_position,
    input  logic signed [plist_pkg::DATA_W-1:0] in_value,
    output logic                                mem_re,
    output logic [ADDR_W-1:0]                   mem_raddr,
    input  logic [ELEM_WIDTH-1:0]               mem_rdata,
    output logic                                mem_we,
    output logic [ADDR_W-1:0]                   mem_waddr,
    output logic [ELEM_WIDTH-1:0]               mem_wdata,
    output logic                                res_valid,
    input  logic                                res_ready,
    output plist_pkg::res_t                     res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_READ  = 5'b00100,
        S_FIND  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   left_reg, left_next;
    logic [ADDR_W-1:0]               rd_addr_reg, rd_addr_next;
    logic                            pend_reg, pend_next;
    logic [ADDR_W-1:0]               pend_addr_reg, pend_addr_next;
    logic [plist_pkg::REQ_W-1:0]     req_reg, req_next;
    logic [ELEM_WIDTH-1:0]           val_reg, val_next;
    logic [ADDR_W-1:0]               pos_idx_reg, pos_idx_next;
    logic [plist_pkg::ST_W-1:0]      status_reg, status_next;
    logic [plist_pkg::DATA_W-1:0]    data_reg, data_next;
    logic [plist_pkg::POS_W-1:0]     found_reg, found_next;

    logic [XW-1:0]     p_ext;
    logic [XW-1:0]     c_ext;
    logic [63:0]       v64;
    logic [63:0]       rd64;
    logic [ADDR_W:0]   pend_pos;

    assign p_ext    = XW'(in_position);
    assign c_ext    = XW'(count_reg);
    assign v64      = 64'($signed(in_value));
    assign rd64     = 64'($signed(mem_rdata));
    assign pend_pos = {1'b0, pend_addr_reg} + (ADDR_W + 1)'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status         = status_reg;
    assign res.data_out       = data_reg;
    assign res.found_position = found_reg;
    assign res.length         = plist_pkg::LEN_W'(count_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        req_next       = req_reg;
        val_next       = val_reg;
        pos_idx_next   = pos_idx_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mem_rdata;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next     = in_req_type;
                    val_next     = v64[ELEM_WIDTH-1:0];
                    pos_idx_next = ADDR_W'(p_ext - XW'(1));
                    status_next  = plist_pkg::ST_OK;
                    data_next    = '0;
                    found_next   = '0;
                    state_next   = S_DONE;
                    case (in_req_type)
                        plist_pkg::REQ_CLEAR: begin
                            count_next = '0;
                        end
                        plist_pkg::REQ_INSERT: begin
                            if (p_ext == '0 || p_ext > c_ext + XW'(1)) begin
                                status_next = plist_pkg::ST_BADPOS;
                            end else if (c_ext >= XW'(CAPACITY)) begin
                                status_next = plist_pkg::ST_FULL;
                            end else begin
                                // Walk down from the last entry, moving each one up.
                                left_next    = CW'(c_ext - p_ext + XW'(1));
                                rd_addr_next = ADDR_W'(c_ext - XW'(1));
                                state_next   = S_SHIFT;
                            end
                        end
                        plist_pkg::REQ_DELETE: begin
                            if (p_ext == '0 || p_ext > c_ext) begin
                                status_next = plist_pkg::ST_BADPOS;
                            end else begin
                                left_next    = CW'(c_ext - p_ext);
                                rd_addr_next = ADDR_W'(p_ext);
                                state_next   = S_SHIFT;
                            end
                        end
                        plist_pkg::REQ_READ: begin
                            if (p_ext == '0 || p_ext > c_ext) begin
                                status_next = plist_pkg::ST_BADPOS;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(p_ext - XW'(1));
                                state_next = S_READ;
                            end
                        end
                        plist_pkg::REQ_FIND: begin
                            if (count_reg == '0) begin
                                status_next = plist_pkg::ST_NOTFOUND;
                            end else begin
                                left_next    = count_reg;
                                rd_addr_next = '0;
                                state_next   = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Each word is written back in the cycle after its read.
                if (left_reg != '0) begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                    left_next      = left_reg - CW'(1);
                    rd_addr_next   = (req_reg == plist_pkg::REQ_INSERT) ?
                                     rd_addr_reg - ADDR_W'(1) : rd_addr_reg + ADDR_W'(1);
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = (req_reg == plist_pkg::REQ_INSERT) ?
                                pend_addr_reg + ADDR_W'(1) : pend_addr_reg - ADDR_W'(1);
                end else if (left_reg == '0) begin
                    if (req_reg == plist_pkg::REQ_INSERT) begin
                        mem_we     = 1'b1;
                        mem_waddr  = pos_idx_reg;
                        mem_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                data_next  = rd64[plist_pkg::DATA_W-1:0];
                state_next = S_DONE;
            end
            S_FIND: begin
                if (pend_reg && mem_rdata == val_reg) begin
                    found_next  = plist_pkg::POS_W'(pend_pos);
                    status_next = plist_pkg::ST_OK;
                    state_next  = S_DONE;
                end else if (left_reg == '0 && !pend_reg) begin
                    status_next = plist_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end else if (left_reg != '0) begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                    left_next      = left_reg - CW'(1);
                    rd_addr_next   = rd_addr_reg + ADDR_W'(1);
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        req_reg       <= req_next;
        val_reg       <= val_next;
        pos_idx_reg   <= pos_idx_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
        found_reg     <= found_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        XW'(count_reg) <= XW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_write_in_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == S_SHIFT)
        else $error("store written outside a shift");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("accepted item did not start");

    a_find_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIND |=> count_reg == $past(count_reg))
        else $error("count changed during a search");

    a_read_needs_rowdata: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_READ |-> $past(mem_re))
        else $error("read result without a store read");
`endif

endmodule

// ----- sv/positional_list_engine.sv -----
// Top level of the positional list engine: sequencer, element store and output register.
`timescale 1ns / 1ps

// Ordered list of signed words held in an internal store of CAPACITY entries.
// Input channel s_*: one request item per handshake (clear, insert, delete,
// read at a 1-based position, or find a value). Result channel m_*: exactly
// one result item per request, carrying status, the word read, the position
// found and the list length after the request.
// Requests are worked one at a time; s_ready is high while the sequencer idles.
// Work per request: clear, an unused code, a bad position, a full list or a
// find in an empty list go straight to the result; a read waits for the
// registered store read; insert moves the entries from p to the end up by
// one, last entry first, then writes the value at p; delete moves the
// entries after p down by one; find reads the entries from the first on
// and stops at the first match.
// The store has one read and one write port, one word moved per cycle. The
// output register holds a result while m_ready is low, and the next request
// is taken meanwhile; its result waits inside until the register frees.
// Reset empties the list; the store itself is not cleared.
module positional_list_engine #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [plist_pkg::REQ_W-1:0]         s_req_type,
    input  logic [plist_pkg::POS_W-1:0]         s_position,
    input  logic signed [plist_pkg::DATA_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [plist_pkg::ST_W-1:0]          m_status,
    output logic signed [plist_pkg::DATA_W-1:0] m_data_out,
    output logic [plist_pkg::POS_W-1:0]         m_found_position,
    output logic [plist_pkg::LEN_W-1:0]         m_length
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ELEM_WIDTH-1:0] mem_rdata;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic                  res_valid;
    logic                  res_ready;
    plist_pkg::res_t       res;

    logic                  m_valid_reg;
    plist_pkg::res_t       out_reg;

    plist_seq #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_req_type (s_req_type),
        .in_position (s_position),
        .in_value    (s_value),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    plist_mem #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_data_out       = out_reg.data_out;
    assign m_found_position = out_reg.found_position;
    assign m_length         = out_reg.length;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the positional list engine: a directed table, then random list work.
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY    = 256;
    localparam int ITEM_TARGET = 1650;
    localparam int LONG_HOLD   = 700;
    localparam int END_SLACK   = 300;
    localparam int TIMEOUT_NS  = 12_000_000;

    // Request codes the block must answer but otherwise ignore.
    localparam logic [plist_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [plist_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [plist_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

    localparam logic signed [plist_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [plist_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [plist_pkg::DATA_W-1:0] VAL_NEG = 32'shFFFF_FFFF;
    localparam logic signed [plist_pkg::DATA_W-1:0] VAL_MID = 32'sh1234_5678;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [plist_pkg::REQ_W-1:0]         s_req_type;
    logic [plist_pkg::POS_W-1:0]         s_position;
    logic signed [plist_pkg::DATA_W-1:0] s_value;
    logic                                m_valid;
    logic                                m_ready;
    logic [plist_pkg::ST_W-1:0]          m_status;
    logic signed [plist_pkg::DATA_W-1:0] m_data_out;
    logic [plist_pkg::POS_W-1:0]         m_found_position;
    logic [plist_pkg::LEN_W-1:0]         m_length;

    typedef struct {
        logic [plist_pkg::REQ_W-1:0]         req;
        logic [plist_pkg::POS_W-1:0]         pos;
        logic signed [plist_pkg::DATA_W-1:0] val;
        bit                                  typed;
        plist_pkg::res_t                     want;
    } step_row_t;

    // Rows with typed set carry the result written out by hand.
    step_row_t directed_rows [25] = '{
        '{plist_pkg::REQ_READ,   9'd1,   32'sd0,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd0}},
        '{plist_pkg::REQ_DELETE, 9'd1,   32'sd0,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd0}},
        '{plist_pkg::REQ_FIND,   9'd0,   32'sd0,  1'b1,
          '{plist_pkg::ST_NOTFOUND, 32'sd0,  9'd0, 9'd0}},
        '{plist_pkg::REQ_INSERT, 9'd0,   32'sd5,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd0}},
        '{plist_pkg::REQ_INSERT, 9'd2,   32'sd5,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd0}},
        '{plist_pkg::REQ_INSERT, 9'd1,   VAL_MAX, 1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd1}},
        '{plist_pkg::REQ_INSERT, 9'd1,   VAL_MIN, 1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd2}},
        '{plist_pkg::REQ_INSERT, 9'd3,   VAL_NEG, 1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd3}},
        '{plist_pkg::REQ_INSERT, 9'd2,   32'sd0,  1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd4}},
        '{plist_pkg::REQ_INSERT, 9'd4,   VAL_MID, 1'b0, '0},
        '{plist_pkg::REQ_READ,   9'd1,   32'sd0,  1'b1,
          '{plist_pkg::ST_OK,       VAL_MIN, 9'd0, 9'd5}},
        '{plist_pkg::REQ_READ,   9'd5,   32'sd0,  1'b1,
          '{plist_pkg::ST_OK,       VAL_NEG, 9'd0, 9'd5}},
        '{plist_pkg::REQ_READ,   9'd6,   32'sd0,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd5}},
        '{plist_pkg::REQ_READ,   9'd511, 32'sd0,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd5}},
        '{plist_pkg::REQ_FIND,   9'd0,   VAL_MAX, 1'b0, '0},
        '{plist_pkg::REQ_FIND,   9'd0,   32'sd77, 1'b1,
          '{plist_pkg::ST_NOTFOUND, 32'sd0,  9'd0, 9'd5}},
        '{REQ_RSVD5,             9'd511, VAL_NEG, 1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd5}},
        '{REQ_RSVD6,             9'd1,   VAL_MAX, 1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd5}},
        '{REQ_RSVD7,             9'd3,   VAL_MIN, 1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd5}},
        '{plist_pkg::REQ_DELETE, 9'd2,   32'sd0,  1'b0, '0},
        '{plist_pkg::REQ_DELETE, 9'd5,   32'sd0,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd4}},
        '{plist_pkg::REQ_DELETE, 9'd0,   32'sd0,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd4}},
        '{plist_pkg::REQ_INSERT, 9'd511, 32'sd9,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd4}},
        '{plist_pkg::REQ_CLEAR,  9'd0,   32'sd0,  1'b1,
          '{plist_pkg::ST_OK,       32'sd0,  9'd0, 9'd0}},
        '{plist_pkg::REQ_READ,   9'd1,   32'sd0,  1'b1,
          '{plist_pkg::ST_BADPOS,   32'sd0,  9'd0, 9'd0}}
    };

    logic signed [plist_pkg::DATA_W-1:0] shadow_list[$];
    plist_pkg::res_t                     pending_results[$];
    bit                                  row_typed;
    plist_pkg::res_t                     row_expect;
    bit                                  sender_quiet;
    bit                                  hold_req;
    int                                  sent_items;
    int                                  fail_count = 0;

    positional_list_engine dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_data_out       (m_data_out),
        .m_found_position (m_found_position),
        .m_length         (m_length)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Applies one request to the shadow list and returns the result it should give.
    function automatic plist_pkg::res_t list_apply(logic [plist_pkg::REQ_W-1:0] req,
                                                   logic [plist_pkg::POS_W-1:0] pos,
                                                   logic signed [plist_pkg::DATA_W-1:0] val);
        plist_pkg::res_t r;
        int              p;
        int              n;
        r = '0;
        p = int'(pos);
        n = shadow_list.size();
        case (req)
            plist_pkg::REQ_CLEAR: shadow_list.delete();
            plist_pkg::REQ_INSERT: begin
                if (p < 1 || p > n + 1)
                    r.status = plist_pkg::ST_BADPOS;
                else if (n >= CAPACITY)
                    r.status = plist_pkg::ST_FULL;
                else
                    shadow_list.insert(p - 1, val);
            end
            plist_pkg::REQ_DELETE: begin
                if (p < 1 || p > n)
                    r.status = plist_pkg::ST_BADPOS;
                else
                    shadow_list.delete(p - 1);
            end
            plist_pkg::REQ_READ: begin
                if (p < 1 || p > n)
                    r.status = plist_pkg::ST_BADPOS;
                else
                    r.data_out = shadow_list[p - 1];
            end
            plist_pkg::REQ_FIND: begin
                r.status = plist_pkg::ST_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (shadow_list[i] == val) begin
                        r.found_position = plist_pkg::POS_W'(i + 1);
                        r.status = plist_pkg::ST_OK;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.length = plist_pkg::LEN_W'(shadow_list.size());
        return r;
    endfunction

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // A small pool of values makes duplicates, so find has to pick the first match.
    function automatic logic signed [plist_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return $urandom_range(0, 7) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [plist_pkg::DATA_W-1:0] pick_probe();
        if (shadow_list.size() > 0 && $urandom_range(0, 9) < 6)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        return pick_value();
    endfunction

    // Valid positions run from 1 to hi; about one in ten is out of range.
    function automatic logic [plist_pkg::POS_W-1:0] pick_position(int hi);
        if (hi < 1 || $urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 0) ? '0 :
                   plist_pkg::POS_W'($urandom_range(hi + 1, 511));
        return plist_pkg::POS_W'($urandom_range(1, hi));
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic [plist_pkg::REQ_W-1:0] req,
                             logic [plist_pkg::POS_W-1:0] pos,
                             logic signed [plist_pkg::DATA_W-1:0] val, bit typed = 1'b0,
                             plist_pkg::res_t want = '0);
        int gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_position <= pos;
        s_value    <= val;
        row_typed  = typed;
        row_expect = want;
        do @(posedge aclk); while (!s_ready);
        if (req < REQ_RSVD5)
            sent_items++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic run_mixed(int count);
        int sz;
        int pick;
        for (int k = 0; k < count; k++) begin
            sz = shadow_list.size();
            pick = $urandom_range(0, 99);
            // Keep the list short outside the fill runs so shifts stay cheap.
            if (sz > 96 && pick >= 5 && pick < 40)
                pick = 40;
            if (pick < 3)
                send_item(plist_pkg::REQ_W'($urandom_range(REQ_RSVD5, REQ_RSVD7)),
                          plist_pkg::POS_W'($urandom), $urandom);
            else if (pick < 5)
                send_item(plist_pkg::REQ_CLEAR, plist_pkg::POS_W'($urandom), $urandom);
            else if (pick < 40)
                send_item(plist_pkg::REQ_INSERT, pick_position(sz + 1), pick_value());
            else if (pick < 60)
                send_item(plist_pkg::REQ_DELETE, pick_position(sz), $urandom);
            else if (pick < 80)
                send_item(plist_pkg::REQ_READ, pick_position(sz), $urandom);
            else
                send_item(plist_pkg::REQ_FIND, plist_pkg::POS_W'($urandom), pick_probe());
        end
    endtask

    // Fills the list to capacity, probes the full list, then trims and clears it.
    task automatic run_fill();
        while (shadow_list.size() < CAPACITY)
            send_item(plist_pkg::REQ_INSERT,
                      plist_pkg::POS_W'($urandom_range(1, shadow_list.size() + 1)),
                      pick_value());
        send_item(plist_pkg::REQ_INSERT, plist_pkg::POS_W'($urandom_range(1, CAPACITY + 1)),
                  pick_value());
        send_item(plist_pkg::REQ_INSERT, plist_pkg::POS_W'(CAPACITY + 1), VAL_MAX);
        send_item(plist_pkg::REQ_INSERT, plist_pkg::POS_W'(CAPACITY + 2), VAL_MIN);
        send_item(plist_pkg::REQ_READ, plist_pkg::POS_W'(CAPACITY), $urandom);
        send_item(plist_pkg::REQ_READ, plist_pkg::POS_W'(CAPACITY + 1), $urandom);
        send_item(plist_pkg::REQ_FIND, plist_pkg::POS_W'($urandom),
                  shadow_list[CAPACITY - 1]);
        send_item(plist_pkg::REQ_FIND, plist_pkg::POS_W'($urandom), $urandom);
        repeat (8)
            send_item(plist_pkg::REQ_DELETE, pick_position(shadow_list.size()), $urandom);
        send_item(plist_pkg::REQ_CLEAR, plist_pkg::POS_W'($urandom), $urandom);
    endtask

    always @(posedge aclk) begin : result_check
        plist_pkg::res_t got;
        plist_pkg::res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_status, m_data_out, m_found_position, m_length};
                if (pending_results.size() == 0) begin
                    $error("result with no request pending");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.data_out !== want.data_out) begin
                        $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
                        fail_count++;
                    end
                    if (got.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, got.found_position);
                        fail_count++;
                    end
                    if (got.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, got.length);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = list_apply(s_req_type, s_position, s_value);
                if (row_typed)
                    want = row_expect;
                pending_results.push_back(want);
            end
        end
    end

    initial begin : receiver
        int left;
        bit hold_done;
        m_ready = 1'b0;
        left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                // Long hold-off so the block fills up and stops taking items.
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_ready <= 1'b1;
                left = 0;
            end else if (left > 0) begin
                left--;
            end else if (m_ready) begin
                left = pick_gap();
                if (left > 0) begin
                    m_ready <= 1'b0;
                    left--;
                end
            end else begin
                m_ready <= 1'b1;
                left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 20);
            end
        end
    end

    initial begin : stimulus
        int episode;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = plist_pkg::REQ_CLEAR;
        s_position   = '0;
        s_value      = '0;
        row_typed    = 1'b0;
        row_expect   = '0;
        sender_quiet = 1'b0;
        hold_req     = 1'b0;
        sent_items   = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].req, directed_rows[i].pos, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        episode = 0;
        while (sent_items < ITEM_TARGET) begin
            sender_quiet = ($urandom_range(0, 4) == 0);
            if (episode == 1)
                hold_req = 1'b1;
            if (episode == 0 || episode == 30)
                run_fill();
            else
                run_mixed($urandom_range(10, 40));
            if (episode == 0 || $urandom_range(0, 7) == 0)
                wait_drained();
            episode++;
        end

        wait_drained();
        repeat (END_SLACK) @(negedge aclk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
